>>> rtl/lss_pkg.sv
// Shared types and codes for the LIFO stack with in-place sort.
package lss_pkg;

   // Opcodes of an input beat
   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP  = 2'd1;
   localparam logic [1:0] OP_SORT = 2'd2;

   // Result status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   // Width of the reported entry count
   localparam int CNT_OUT_W = 11;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] push_value;
   } lss_req_type;

   typedef struct packed {
      logic signed [31:0]     result_value;
      logic [1:0]             status;
      logic [CNT_OUT_W-1:0]   item_count;
      logic                   is_empty;
   } lss_rsp_type;

   // Source of the result word
   typedef enum logic [1:0] {
      SRC_ZERO = 2'd0,
      SRC_PUSH = 2'd1,
      SRC_MEM  = 2'd2
   } lss_src_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic        push_wr;     // store push word at count, count + 1
      logic        pop_dec;     // count - 1
      logic        sort_begin;  // read entry 1, i = 1
      logic        key_load;    // key = read data, j = i, read entry i - 1
      logic        cmp_shift;   // entry j = read data, j - 1, read entry j - 2
      logic        key_place;   // entry j = key, i + 1, read entry i + 1
      logic        rsp_valid;   // register a result beat
      lss_src_type rsp_src;
      logic [1:0]  rsp_status;
   } lss_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic empty;     // no entries stored
      logic full;      // every entry holds a word
      logic lt_two;    // fewer than two entries
      logic greater;   // read entry orders above the key
      logic j_one;     // j has reached entry 1, so the read entry is entry 0
      logic i_last;    // current key is the last stored entry
   } lss_stat_type;

endpackage

>>> rtl/lss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lss_ctrl.sv
// Controller state machine: sequences push, pop and the insertion sort.
module lss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           opcode,
   input  lss_pkg::lss_stat_type stat,
   output logic                 busy,
   output lss_pkg::lss_cmd_type  cmd
);
   import lss_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_TOP   = 6'b000010,
      ST_KEY   = 6'b000100,
      ST_CMP   = 6'b001000,
      ST_PLACE = 6'b010000,
      ST_FIN   = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] pend_ff, pend_in;

   // next state and command decode
   always_comb begin
      cmd      = '0;
      cmd.rsp_src = SRC_ZERO;
      state_in = state_ff;
      pend_in  = pend_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (opcode == OP_PUSH) begin
                  if (stat.full) begin
                     cmd.sort_begin = 1'b0;
                     pend_in  = STAT_FULL;
                     state_in = ST_TOP;
                  end else begin
                     cmd.push_wr    = 1'b1;
                     cmd.rsp_valid  = 1'b1;
                     cmd.rsp_src    = SRC_PUSH;
                     cmd.rsp_status = STAT_OK;
                  end
               end else if (opcode == OP_POP) begin
                  if (stat.empty) begin
                     cmd.rsp_valid  = 1'b1;
                     cmd.rsp_src    = SRC_ZERO;
                     cmd.rsp_status = STAT_EMPTY;
                  end else begin
                     cmd.pop_dec = 1'b1;
                     pend_in  = STAT_OK;
                     state_in = ST_TOP;
                  end
               end else if (opcode == OP_SORT && !stat.lt_two) begin
                  cmd.sort_begin = 1'b1;
                  pend_in  = STAT_OK;
                  state_in = ST_KEY;
               end else begin
                  // short sort or no-op: report the top entry, or zero when empty
                  if (stat.empty) begin
                     cmd.rsp_valid  = 1'b1;
                     cmd.rsp_src    = SRC_ZERO;
                     cmd.rsp_status = STAT_OK;
                  end else begin
                     pend_in  = STAT_OK;
                     state_in = ST_TOP;
                  end
               end
            end
         end
         ST_TOP: begin
            // top entry read last cycle is on the RAM output
            cmd.rsp_valid  = 1'b1;
            cmd.rsp_src    = SRC_MEM;
            cmd.rsp_status = pend_ff;
            state_in       = ST_IDLE;
         end
         ST_KEY: begin
            cmd.key_load = 1'b1;
            state_in     = ST_CMP;
         end
         ST_CMP: begin
            if (stat.greater) begin
               cmd.cmp_shift = 1'b1;
               if (stat.j_one) begin
                  state_in = ST_PLACE;
               end
            end else begin
               cmd.key_place = 1'b1;
               state_in = stat.i_last ? ST_FIN : ST_KEY;
            end
         end
         ST_PLACE: begin
            cmd.key_place = 1'b1;
            state_in = stat.i_last ? ST_FIN : ST_KEY;
         end
         ST_FIN: begin
            // last write may hit the top entry, so read it here, after that write
            state_in = ST_TOP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= STAT_OK;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

>>> rtl/lss_dp.sv
// Datapath: entry count, sort indexes, key register, stack RAM and result register.
module lss_dp #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lss_pkg::lss_req_type  req_data,
   input  lss_pkg::lss_cmd_type  cmd,
   output lss_pkg::lss_stat_type stat,
   output logic                 rsp_valid,
   output lss_pkg::lss_rsp_type  rsp_data
);
   import lss_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]                count_ff, count_in;
   logic [AW-1:0]                i_ff, i_in;
   logic [AW-1:0]                j_ff, j_in;
   logic signed [DATA_WIDTH-1:0] key_ff, key_in;
   logic                         rsp_valid_ff;
   lss_rsp_type                  rsp_ff, rsp_in;

   logic                         wr_en;
   logic [AW-1:0]                wr_addr, rd_addr, top_addr;
   logic signed [DATA_WIDTH-1:0] wr_data, rd_data;
   logic signed [63:0]           push_wide, sel_wide;
   logic signed [DATA_WIDTH-1:0] push_word, sel_word;

   lss_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // push word: sign-extend the 32-bit field, keep DATA_WIDTH bits
   assign push_wide = 64'(req_data.push_value);
   assign push_word = push_wide[DATA_WIDTH-1:0];
   assign top_addr  = AW'(count_ff - CW'(1));

   // status toward the controller
   assign stat.empty   = (count_ff == '0);
   assign stat.full    = (count_ff == CW'(DEPTH));
   assign stat.lt_two  = (count_ff < CW'(2));
   assign stat.greater = (rd_data > key_ff);
   assign stat.j_one   = (j_ff == AW'(1));
   assign stat.i_last  = ((CW'(i_ff) + CW'(1)) == count_ff);

   // RAM ports and index updates
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = j_ff;
      wr_data  = key_ff;
      rd_addr  = top_addr;
      count_in = count_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      key_in   = key_ff;
      if (cmd.push_wr) begin
         wr_en    = 1'b1;
         wr_addr  = AW'(count_ff);
         wr_data  = push_word;
         count_in = count_ff + CW'(1);
      end
      if (cmd.pop_dec) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.sort_begin) begin
         rd_addr = AW'(1);
         i_in    = AW'(1);
      end
      if (cmd.key_load) begin
         key_in  = rd_data;
         j_in    = i_ff;
         rd_addr = i_ff - AW'(1);
      end
      if (cmd.cmp_shift) begin
         wr_en   = 1'b1;
         wr_addr = j_ff;
         wr_data = rd_data;
         j_in    = j_ff - AW'(1);
         rd_addr = j_ff - AW'(2);
      end
      if (cmd.key_place) begin
         wr_en   = 1'b1;
         wr_addr = j_ff;
         wr_data = key_ff;
         i_in    = i_ff + AW'(1);
         rd_addr = i_ff + AW'(1);
      end
   end

   // result word: sign-extend the selected word, keep 32 bits
   always_comb begin
      case (cmd.rsp_src)
         SRC_PUSH: sel_word = push_word;
         SRC_MEM:  sel_word = rd_data;
         default:  sel_word = '0;
      endcase
      sel_wide            = 64'(sel_word);
      rsp_in.result_value = sel_wide[31:0];
      rsp_in.status       = cmd.rsp_status;
      rsp_in.item_count   = CNT_OUT_W'(count_in);
      rsp_in.is_empty     = (count_in == '0);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.rsp_valid;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      j_ff   <= j_in;
      key_ff <= key_in;
      if (cmd.rsp_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/lifo_stack_with_sort_core.sv
// Top level of the LIFO stack with in-place ascending sort.
// Push that stores: result beat in the cycle after start; busy stays low.
// Pop, refused push, no-op and short sort: result via ST_TOP, busy meanwhile; if empty, as push.
// Sort: the insertion sort walks the stack RAM one entry at a time, as set by the single read
// port of the stack RAM; its result then comes from ST_TOP like a pop.
// Reset clears the entry count and control only; the RAM is not cleared. Results cannot stall.
module lifo_stack_with_sort_core #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  lss_pkg::lss_req_type req_data,
   output logic                rsp_valid,
   output lss_pkg::lss_rsp_type rsp_data
);
   import lss_pkg::*;

   lss_cmd_type  cmd;
   lss_stat_type stat;

   lss_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_data.opcode),
      .stat   (stat),
      .busy   (busy),
      .cmd    (cmd)
   );

   lss_dp #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
